FILE: rtl/baro_pkg.sv
// shared types and constants for barometer compensation
`default_nettype none
package baro_pkg;

	typedef struct packed {
		logic        operation;
		logic [23:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
		logic               divide_error;
	} out_item_t;

	// register indexes
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	// datapath micro-operations
	typedef enum logic [4:0] {
		DP_T_X1A, DP_T_X1B, DP_T_X1C, DP_T_DEN, DP_T_DIVSET, DP_T_FIN,
		DP_P_B6, DP_P_SQ, DP_P_X1, DP_P_X2, DP_P_B3, DP_P_X1B, DP_P_X2B,
		DP_P_B4, DP_P_B7, DP_P_DIVSET, DP_P_PSET, DP_P_Q1, DP_P_Q2,
		DP_P_Q3, DP_P_FIN, DP_NOP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_div;
		logic div_busy;
	} dp_stat_t;

	localparam logic [31:0] C_4000  = 32'd4000;
	localparam logic [31:0] C_50000 = 32'd50000;
	localparam logic [31:0] C_3038  = 32'd3038;
	localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
	localparam logic [31:0] C_3791  = 32'd3791;
	localparam logic [31:0] C_32768 = 32'd32768;

endpackage
`default_nettype wire

FILE: rtl/baro_div.sv
// unsigned 32-bit restoring divider, one quotient bit per cycle
`default_nettype none
module baro_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};
	assign quotient = quo_q;

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= 6'd32;
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			busy  <= (cnt_q != 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/baro_datapath.sv
// compensation datapath: shared multiplier, divider and work registers
`default_nettype none
module baro_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire baro_pkg::dp_cmd_t  cmd,
	input  wire baro_pkg::in_item_t in_item,
	input  wire logic [31:0]        ac1_ac2,
	input  wire logic [31:0]        ac3_ac4,
	input  wire logic [31:0]        ac5_ac6,
	input  wire logic [31:0]        b1_b2,
	input  wire logic [31:0]        mc_md,
	input  wire logic [1:0]         oss,
	output baro_pkg::dp_stat_t      stat,
	output logic signed [31:0]      result
);
	logic [31:0] b5_q, a_q, b_q, c_q, sq_q, b6_q, x3_q, b3_q, b4_q, b7_q, p_q, t_q;
	logic        neg_q;
	logic [23:0] raw_q;
	logic [31:0] mul_a, mul_b, prod;
	logic        div_start, div_busy;
	logic [31:0] div_n, div_d, div_qo;
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] up, qs;

	assign ac1 = {{16{ac1_ac2[31]}}, ac1_ac2[31:16]};
	assign ac2 = {{16{ac1_ac2[15]}}, ac1_ac2[15:0]};
	assign ac3 = {{16{ac3_ac4[31]}}, ac3_ac4[31:16]};
	assign ac4 = {16'd0, ac3_ac4[15:0]};
	assign ac5 = {16'd0, ac5_ac6[31:16]};
	assign ac6 = {16'd0, ac5_ac6[15:0]};
	assign b1  = {{16{b1_b2[31]}}, b1_b2[31:16]};
	assign b2  = {{16{b1_b2[15]}}, b1_b2[15:0]};
	assign mc  = {{16{mc_md[31]}}, mc_md[31:16]};
	assign md  = {{16{mc_md[15]}}, mc_md[15:0]};
	assign up  = {8'd0, raw_q} >> (4'd8 - {2'd0, oss});
	assign qs  = neg_q ? (32'd0 - div_qo) : div_qo;

	// operand select for the shared 32x32 low-half multiplier
	always_comb begin
		mul_a = a_q;
		mul_b = b_q;
		case (cmd.op)
			baro_pkg::DP_T_X1A: begin mul_a = a_q;  mul_b = ac5; end
			baro_pkg::DP_P_SQ:  begin mul_a = b6_q; mul_b = b6_q; end
			baro_pkg::DP_P_X1:  begin mul_a = b2;   mul_b = sq_q; end
			baro_pkg::DP_P_X2:  begin mul_a = ac2;  mul_b = b6_q; end
			baro_pkg::DP_P_X1B: begin mul_a = ac3;  mul_b = b6_q; end
			baro_pkg::DP_P_X2B: begin mul_a = b1;   mul_b = sq_q; end
			baro_pkg::DP_P_B4:  begin mul_a = ac4;  mul_b = x3_q; end
			baro_pkg::DP_P_B7:
				begin mul_a = up - b3_q; mul_b = baro_pkg::C_50000 >> oss; end
			baro_pkg::DP_P_Q1:  begin mul_a = a_q;  mul_b = a_q; end
			baro_pkg::DP_P_Q2:  begin mul_a = a_q;  mul_b = baro_pkg::C_3038; end
			baro_pkg::DP_P_Q3:  begin mul_a = baro_pkg::C_M7357; mul_b = p_q; end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// divider operands
	always_comb begin
		div_start = 1'b0;
		div_n = '0;
		div_d = '0;
		case (cmd.op)
			baro_pkg::DP_T_DIVSET: begin
				div_start = 1'b1;
				div_n = mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
				div_d = c_q[31] ? (32'd0 - c_q) : c_q;
			end
			baro_pkg::DP_P_DIVSET: begin
				div_start = 1'b1;
				div_n = b7_q[31] ? b7_q : (b7_q << 1);
				div_d = b4_q;
			end
			default: ;
		endcase
	end

	baro_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quotient (div_qo)
	);

	assign stat.div_busy = div_busy;
	assign stat.zero_div = (cmd.op == baro_pkg::DP_P_DIVSET) ? (b4_q == 32'd0)
	                                                         : (c_q == 32'd0);
	assign result = $signed(t_q);

	// stored b5 survives between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= '0;
		end else if (cmd.op == baro_pkg::DP_T_FIN) begin
			b5_q <= a_q + qs;
		end
	end

	// work registers stepped by the controller
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= in_item.raw_sample;
			a_q   <= {16'd0, in_item.raw_sample[15:0]} - ac6;
			// result reads zero unless the item completes
			t_q   <= '0;
		end
		case (cmd.op)
			baro_pkg::DP_T_X1A: b_q <= prod;
			baro_pkg::DP_T_X1B: begin
				// truncating divide by 32768
				a_q <= $unsigned($signed(b_q[31] ? b_q + 32'd32767 : b_q) >>> 15);
			end
			baro_pkg::DP_T_DEN: c_q <= a_q + md;
			baro_pkg::DP_T_DIVSET: neg_q <= mc[31] ^ c_q[31];
			baro_pkg::DP_T_FIN: t_q <= $unsigned($signed(a_q + qs + 32'd8) >>> 4);
			baro_pkg::DP_P_B6:  b6_q <= b5_q - baro_pkg::C_4000;
			baro_pkg::DP_P_SQ:  sq_q <= $unsigned($signed(prod) >>> 12);
			baro_pkg::DP_P_X1:  x3_q <= $unsigned($signed(prod) >>> 11);
			baro_pkg::DP_P_X2:  x3_q <= x3_q + $unsigned($signed(prod) >>> 11);
			baro_pkg::DP_P_B3:
				b3_q <= $unsigned($signed((((ac1 << 2) + x3_q) << oss) + 32'd2) >>> 2);
			baro_pkg::DP_P_X1B: a_q <= $unsigned($signed(prod) >>> 13);
			baro_pkg::DP_P_X2B:
				x3_q <= $unsigned($signed(a_q + $unsigned($signed(prod) >>> 16)
				        + 32'd2) >>> 2) + baro_pkg::C_32768;
			baro_pkg::DP_P_B4:  b4_q <= prod >> 15;
			baro_pkg::DP_P_B7:  b7_q <= prod;
			baro_pkg::DP_P_DIVSET: neg_q <= 1'b0;
			baro_pkg::DP_P_PSET: begin
				p_q <= b7_q[31] ? (div_qo << 1) : div_qo;
				a_q <= $unsigned($signed(b7_q[31] ? (div_qo << 1) : div_qo) >>> 8);
			end
			baro_pkg::DP_P_Q1:  a_q <= prod;
			baro_pkg::DP_P_Q2:  a_q <= $unsigned($signed(prod) >>> 16);
			baro_pkg::DP_P_Q3:  b_q <= $unsigned($signed(prod) >>> 16);
			baro_pkg::DP_P_FIN:
				t_q <= p_q + $unsigned($signed(a_q + b_q + baro_pkg::C_3791) >>> 4);
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/baro_ctrl.sv
// sequencer that steps the datapath through one compensation item
`default_nettype none
module baro_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic               operation,
	input  wire logic               out_fire,
	input  wire baro_pkg::dp_stat_t stat,
	output baro_pkg::dp_cmd_t       cmd,
	output logic                    busy,
	output logic                    out_valid,
	output logic                    out_kind,
	output logic                    out_err
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_DONE} state_t;
	state_t           state_q;
	baro_pkg::dp_op_t step_q;

	assign busy = (state_q != S_IDLE);
	assign cmd.load = in_fire;
	assign cmd.op = (state_q == S_RUN) ? step_q : baro_pkg::DP_NOP;

	// state, step and registered result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= baro_pkg::DP_NOP;
			out_valid <= 1'b0;
			out_kind  <= 1'b0;
			out_err   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q  <= S_RUN;
					out_kind <= operation;
					out_err  <= 1'b0;
					step_q   <= (operation == baro_pkg::OP_TEMP) ? baro_pkg::DP_T_X1A
					                                             : baro_pkg::DP_P_B6;
				end
				S_RUN: begin
					unique case (step_q)
						baro_pkg::DP_T_DIVSET, baro_pkg::DP_P_DIVSET: begin
							if (stat.zero_div) begin
								out_err   <= 1'b1;
								state_q   <= S_DONE;
								out_valid <= 1'b1;
							end else begin
								state_q <= S_WAIT;
							end
						end
						baro_pkg::DP_T_FIN, baro_pkg::DP_P_FIN: begin
							state_q   <= S_DONE;
							out_valid <= 1'b1;
						end
						baro_pkg::DP_T_X1A:  step_q <= baro_pkg::DP_T_X1B;
						baro_pkg::DP_T_X1B:  step_q <= baro_pkg::DP_T_DEN;
						baro_pkg::DP_T_DEN:  step_q <= baro_pkg::DP_T_DIVSET;
						baro_pkg::DP_P_B6:   step_q <= baro_pkg::DP_P_SQ;
						baro_pkg::DP_P_SQ:   step_q <= baro_pkg::DP_P_X1;
						baro_pkg::DP_P_X1:   step_q <= baro_pkg::DP_P_X2;
						baro_pkg::DP_P_X2:   step_q <= baro_pkg::DP_P_B3;
						baro_pkg::DP_P_B3:   step_q <= baro_pkg::DP_P_X1B;
						baro_pkg::DP_P_X1B:  step_q <= baro_pkg::DP_P_X2B;
						baro_pkg::DP_P_X2B:  step_q <= baro_pkg::DP_P_B4;
						baro_pkg::DP_P_B4:   step_q <= baro_pkg::DP_P_B7;
						baro_pkg::DP_P_B7:   step_q <= baro_pkg::DP_P_DIVSET;
						baro_pkg::DP_P_PSET: step_q <= baro_pkg::DP_P_Q1;
						baro_pkg::DP_P_Q1:   step_q <= baro_pkg::DP_P_Q2;
						baro_pkg::DP_P_Q2:   step_q <= baro_pkg::DP_P_Q3;
						baro_pkg::DP_P_Q3:   step_q <= baro_pkg::DP_P_FIN;
						default:             state_q <= S_IDLE;
					endcase
				end
				S_WAIT: if (!stat.div_busy) begin
					state_q <= S_RUN;
					step_q  <= (step_q == baro_pkg::DP_T_DIVSET) ? baro_pkg::DP_T_FIN
					                                             : baro_pkg::DP_P_PSET;
				end
				S_DONE: if (out_fire) begin
					state_q   <= S_IDLE;
					out_valid <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/barometer_compensation.sv
// barometer compensation top level: config registers, controller, datapath
// a result is valid once the controller has stepped through the item, waiting on
// the serial divider, with one shared multiplier step per product; a zero divisor
// ends the item without waiting on the divider
// one item at a time; the next transfer can come the cycle after the result
// transfer
// reset: all config registers and the stored b5 clear to zero
`default_nettype none
module barometer_compensation (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire baro_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output baro_pkg::out_item_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
	logic [1:0]  oss_q;
	logic        busy, in_fire, out_fire, kind, err;
	logic [2:0]  reg_idx;
	logic signed [31:0] result;
	baro_pkg::dp_cmd_t  cmd;
	baro_pkg::dp_stat_t stat;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[4:2];
	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign out_data = '{kind: kind, value: result, divide_error: err};

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0; ac3_ac4_q <= '0; ac5_ac6_q <= '0;
			b1_b2_q <= '0; mc_md_q <= '0; oss_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				baro_pkg::REG_AC1_AC2: ac1_ac2_q <= pwdata;
				baro_pkg::REG_AC3_AC4: ac3_ac4_q <= pwdata;
				baro_pkg::REG_AC5_AC6: ac5_ac6_q <= pwdata;
				baro_pkg::REG_B1_B2:   b1_b2_q   <= pwdata;
				baro_pkg::REG_MC_MD:   mc_md_q   <= pwdata;
				baro_pkg::REG_OSS:     oss_q     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			baro_pkg::REG_AC1_AC2: prdata = ac1_ac2_q;
			baro_pkg::REG_AC3_AC4: prdata = ac3_ac4_q;
			baro_pkg::REG_AC5_AC6: prdata = ac5_ac6_q;
			baro_pkg::REG_B1_B2:   prdata = b1_b2_q;
			baro_pkg::REG_MC_MD:   prdata = mc_md_q;
			baro_pkg::REG_OSS:     prdata = {30'd0, oss_q};
			default:               prdata = '0;
		endcase
	end

	baro_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.operation (in_data.operation),
		.out_fire  (out_fire),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (out_valid),
		.out_kind  (kind),
		.out_err   (err)
	);

	baro_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_data),
		.ac1_ac2 (ac1_ac2_q),
		.ac3_ac4 (ac3_ac4_q),
		.ac5_ac6 (ac5_ac6_q),
		.b1_b2   (b1_b2_q),
		.mc_md   (mc_md_q),
		.oss     (oss_q),
		.stat    (stat),
		.result  (result)
	);

`ifndef ASSERT_OFF
	// an error result always carries value zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.divide_error) |-> (out_data.value == 0))
		else $error("error result with nonzero value");
	// no new item while a result is pending
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");
	// a transferred result clears valid next cycle
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> !out_valid)
		else $error("result repeated");
`endif
endmodule
`default_nettype wire

FILE: bench/barometer_compensation_tb.sv
// testbench for barometer compensation: directed table, random items, predictor check
module barometer_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int N_RANDOM       = 500;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	baro_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	baro_pkg::out_item_t out_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [4:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	barometer_compensation DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// predictor copy of calibration and state
	logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
	logic [1:0]  cal_oss;
	logic [31:0] stored_b5;

	baro_pkg::out_item_t pending_results[$];
	int                  error_count = 0;
	int                  idle_cycles = 0;

	function automatic logic [31:0] sext16(input logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// compensation of one reading, updates stored b5
	function automatic baro_pkg::out_item_t compensate(input baro_pkg::in_item_t item);
		baro_pkg::out_item_t r;
		logic [31:0] ut, x1, x2, x3, den, up, b6, sq, b3, b4, b7, p;
		logic [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
		int          oss;
		ac1 = sext16(cal_ac1_ac2[31:16]);
		ac2 = sext16(cal_ac1_ac2[15:0]);
		ac3 = sext16(cal_ac3_ac4[31:16]);
		ac4 = {16'd0, cal_ac3_ac4[15:0]};
		ac5 = {16'd0, cal_ac5_ac6[31:16]};
		ac6 = {16'd0, cal_ac5_ac6[15:0]};
		b1  = sext16(cal_b1_b2[31:16]);
		b2  = sext16(cal_b1_b2[15:0]);
		mc  = sext16(cal_mc_md[31:16]);
		md  = sext16(cal_mc_md[15:0]);
		oss = cal_oss;
		r.kind = item.operation;
		r.value = '0;
		r.divide_error = 1'b0;
		if (item.operation == baro_pkg::OP_TEMP) begin
			ut = {16'd0, item.raw_sample[15:0]};
			x1 = div_trunc((ut - ac6) * ac5, 32'd32768);
			den = x1 + md;
			if (den == 0) begin
				r.divide_error = 1'b1;
			end else begin
				x2 = div_trunc(mc * 32'd2048, den);
				stored_b5 = x1 + x2;
				r.value = $signed(stored_b5 + 32'd8) >>> 4;
			end
		end else begin
			up = {8'd0, item.raw_sample} >> (8 - oss);
			b6 = stored_b5 - 32'd4000;
			sq = $signed(b6 * b6) >>> 12;
			x1 = $signed(b2 * sq) >>> 11;
			x2 = $signed(ac2 * b6) >>> 11;
			x3 = x1 + x2;
			b3 = $signed(((ac1 * 32'd4 + x3) << oss) + 32'd2) >>> 2;
			x1 = $signed(ac3 * b6) >>> 13;
			x2 = $signed(b1 * sq) >>> 16;
			x3 = $signed(x1 + x2 + 32'd2) >>> 2;
			b4 = (ac4 * (x3 + 32'd32768)) >> 15;
			b7 = (up - b3) * (32'd50000 >> oss);
			if (b4 == 0) begin
				r.divide_error = 1'b1;
			end else begin
				if (!b7[31]) p = (b7 * 32'd2) / b4;
				else p = (b7 / b4) * 32'd2;
				x1 = ($signed(p) >>> 8) * ($signed(p) >>> 8);
				x1 = $signed(x1 * 32'd3038) >>> 16;
				x2 = $signed(32'hFFFF_E343 * p) >>> 16;
				p = p + $unsigned($signed(x1 + x2 + 32'd3791) >>> 4);
				r.value = p;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			idle_cycles <= 0;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", out_data.value, 32'd0);
			end else begin
				baro_pkg::out_item_t want;
				want = pending_results.pop_front();
				if (out_data.kind !== want.kind)
					report_mismatch("kind", {31'd0, out_data.kind}, {31'd0, want.kind});
				if (out_data.value !== want.value)
					report_mismatch("value", out_data.value, want.value);
				if (out_data.divide_error !== want.divide_error)
					report_mismatch("divide_error", {31'd0, out_data.divide_error},
						{31'd0, want.divide_error});
			end
		end else if (arst_n && in_valid && in_ready) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
			else if ($urandom_range(0, 9) < 3)
				out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ~out_ready;
			else out_ready <= 1'b1;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
		return $urandom_range(1, 4);
	endfunction

	// register write, setup then access, then idle, then the predictor copy is updated
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			baro_pkg::REG_AC1_AC2: cal_ac1_ac2 = v;
			baro_pkg::REG_AC3_AC4: cal_ac3_ac4 = v;
			baro_pkg::REG_AC5_AC6: cal_ac5_ac6 = v;
			baro_pkg::REG_B1_B2:   cal_b1_b2 = v;
			baro_pkg::REG_MC_MD:   cal_mc_md = v;
			baro_pkg::REG_OSS:     cal_oss = v[1:0];
			default: ;
		endcase
	endtask

	task automatic write_calibration(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic [31:0] e,
			input logic [1:0] o);
		write_reg(baro_pkg::REG_AC1_AC2, a);
		write_reg(baro_pkg::REG_AC3_AC4, b);
		write_reg(baro_pkg::REG_AC5_AC6, c);
		write_reg(baro_pkg::REG_B1_B2, d);
		write_reg(baro_pkg::REG_MC_MD, e);
		write_reg(baro_pkg::REG_OSS, {30'd0, o});
	endtask

	// one input transfer, with the expected result queued; valid stays high
	// into the next transfer when there is no gap
	task automatic send_reading(input baro_pkg::in_item_t item, input bit typed,
			input baro_pkg::out_item_t typed_res);
		int gap;
		baro_pkg::out_item_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		res = compensate(item);
		if (typed && res !== typed_res)
			report_mismatch("predictor vs table", res.value, typed_res.value);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(res);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	typedef struct {
		logic        op;
		logic [23:0] raw;
		bit          typed;
		logic [31:0] value;
		logic        err;
	} row_t;

	row_t rows[$];

	function automatic baro_pkg::in_item_t mk(input logic op, input logic [23:0] raw);
		baro_pkg::in_item_t i;
		i.operation = op;
		i.raw_sample = raw;
		return i;
	endfunction

	// typical calibration set
	localparam logic [31:0] CAL_A = {16'd408, 16'hFFC8};
	localparam logic [31:0] CAL_B = {16'hC6D1, 16'd32741};
	localparam logic [31:0] CAL_C = {16'd32757, 16'd23153};
	localparam logic [31:0] CAL_D = {16'd6190, 16'd4};
	localparam logic [31:0] CAL_E = {16'hD4BD, 16'd2868};

	initial begin
		baro_pkg::in_item_t  item;
		baro_pkg::out_item_t tres;
		int                  k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cal_ac1_ac2 = 0; cal_ac3_ac4 = 0; cal_ac5_ac6 = 0;
		cal_b1_b2 = 0; cal_mc_md = 0; cal_oss = 0; stored_b5 = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: all zero calibration gives divide errors
		rows.push_back('{baro_pkg::OP_TEMP, 24'h000000, 1, 32'd0, 1'b1});
		rows.push_back('{baro_pkg::OP_PRESS, 24'hFFFFFF, 1, 32'd0, 1'b1});
		foreach (rows[i]) begin
			tres.kind = rows[i].op; tres.value = rows[i].value;
			tres.divide_error = rows[i].err;
			send_reading(mk(rows[i].op, rows[i].raw), rows[i].typed, tres);
		end
		drain();

		// typical calibration, extremes of raw, every oversampling
		write_calibration(CAL_A, CAL_B, CAL_C, CAL_D, CAL_E, 2'd0);
		rows.delete();
		rows.push_back('{baro_pkg::OP_PRESS, 24'h5D23A0, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_TEMP, 24'h006CFA, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_PRESS, 24'h5D23A0, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_TEMP, 24'hFF6CFA, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_TEMP, 24'h000000, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_TEMP, 24'h00FFFF, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_PRESS, 24'h000000, 0, 0, 0});
		rows.push_back('{baro_pkg::OP_PRESS, 24'hFFFFFF, 0, 0, 0});
		foreach (rows[i]) send_reading(mk(rows[i].op, rows[i].raw), 0, tres);
		for (k = 1; k < 4; k++) begin
			drain();
			write_reg(baro_pkg::REG_OSS, k);
			send_reading(mk(baro_pkg::OP_PRESS, 24'h5D23A0), 0, tres);
			send_reading(mk(baro_pkg::OP_PRESS, 24'hFFFFFF), 0, tres);
		end
		drain();

		// temperature divisor zero: x1 and md both zero (ut == ac6 gives x1 = 0, md = 0)
		write_calibration(CAL_A, CAL_B, CAL_C, CAL_D, {16'hD4BD, 16'd0}, 2'd3);
		send_reading(mk(baro_pkg::OP_TEMP, 24'h005A71), 1,
			'{baro_pkg::OP_TEMP, 32'd0, 1'b1});
		send_reading(mk(baro_pkg::OP_PRESS, 24'h123456), 0, tres);
		drain();

		// extreme calibration words
		write_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		send_reading(mk(baro_pkg::OP_TEMP, 24'h00FFFF), 0, tres);
		send_reading(mk(baro_pkg::OP_TEMP, 24'h000000), 0, tres);
		send_reading(mk(baro_pkg::OP_PRESS, 24'hFFFFFF), 0, tres);
		drain();
		write_calibration(32'h8000_8000, 32'h8000_0000, 32'h8000_8000,
			32'h8000_8000, 32'h8000_8000, 2'd0);
		send_reading(mk(baro_pkg::OP_TEMP, 24'h00FFFF), 0, tres);
		send_reading(mk(baro_pkg::OP_PRESS, 24'h000000), 0, tres);
		drain();

		// random phases: mostly near-typical calibration, some fully random
		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 2)
				write_calibration($urandom, $urandom, $urandom, $urandom, $urandom,
					2'($urandom_range(0, 3)));
			else
				write_calibration(CAL_A ^ ($urandom & 32'h00FF_00FF),
					CAL_B ^ ($urandom & 32'h00FF_0FFF),
					CAL_C ^ ($urandom & 32'h00FF_0FFF),
					CAL_D ^ ($urandom & 32'h00FF_000F),
					CAL_E ^ ($urandom & 32'h00FF_00FF), 2'($urandom_range(0, 3)));
			for (int n = 0; n < N_RANDOM / 10; n++) begin
				if ($urandom_range(0, 4) == 0)
					item = mk(1'($urandom_range(0, 1)), 24'($urandom));
				else if ($urandom_range(0, 2) == 0)
					item = mk(baro_pkg::OP_TEMP,
						{8'($urandom), 16'($urandom_range(20000, 35000))});
				else
					item = mk(baro_pkg::OP_PRESS,
						24'($urandom_range(24'h300000, 24'hB00000)));
				send_reading(item, 0, tres);
			end
			drain();
		end

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
